// ===== rtl/core/ihdp_pkg.sv =====
// Shared types and constants of the image header dimension parser.
`timescale 1ns / 1ps
`default_nettype none

package ihdp_pkg;

  typedef enum logic [1:0] {
    FMT_JPEG  = 2'd0,
    FMT_PNG   = 2'd1,
    FMT_GIF   = 2'd2,
    FMT_OTHER = 2'd3
  } fmt_t;

  // Phases of the JPEG scan: marker search, three skipped bytes, four size bytes
  typedef enum logic [2:0] {
    PH_SEARCH = 3'd0,
    PH_SKIP1  = 3'd1,
    PH_SKIP2  = 3'd2,
    PH_SKIP3  = 3'd3,
    PH_H_HI   = 3'd4,
    PH_H_LO   = 3'd5,
    PH_W_HI   = 3'd6,
    PH_W_LO   = 3'd7
  } phase_t;

  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] BYTE_SOF0 = 8'hC0;
  localparam logic [7:0] BYTE_89   = 8'h89;
  localparam logic [7:0] CHAR_P    = 8'h50;
  localparam logic [7:0] CHAR_N    = 8'h4E;
  localparam logic [7:0] CHAR_G    = 8'h47;
  localparam logic [7:0] CHAR_I    = 8'h49;
  localparam logic [7:0] CHAR_F    = 8'h46;

  localparam int POS_W = 5;
  localparam logic [POS_W-1:0] POS_MAX = 5'd31;

  localparam int DIM_W   = 32;
  localparam int OUT_W   = 72;  // 65 payload bits padded to whole bytes

  typedef struct packed {
    logic             found;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/ihdp_parse.sv =====
// Per-file parse state and the combinational step that consumes one byte.
`timescale 1ns / 1ps
`default_nettype none

module ihdp_parse (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ihdp_pkg::fmt_t  image_format,
  input  wire logic            advance,
  input  wire logic [7:0]      file_byte,
  input  wire logic            last_byte,
  output logic                 res_valid,
  output ihdp_pkg::result_t    res
);
  import ihdp_pkg::*;

  logic [POS_W-1:0] byte_position, byte_position_next;
  phase_t           parse_phase, parse_phase_next;
  logic             previous_was_ff, previous_was_ff_next;
  logic             signature_ok, signature_ok_next;
  logic [DIM_W-1:0] width_shift, width_shift_next;
  logic [DIM_W-1:0] height_shift, height_shift_next;
  logic             result_sent, result_sent_next;

  always_comb begin
    byte_position_next   = byte_position;
    parse_phase_next     = parse_phase;
    previous_was_ff_next = previous_was_ff;
    signature_ok_next    = signature_ok;
    width_shift_next     = width_shift;
    height_shift_next    = height_shift;
    result_sent_next     = result_sent;
    res_valid            = 1'b0;
    res                  = '0;

    if (!result_sent) begin
      case (image_format)
        FMT_JPEG: begin
          case (parse_phase)
            PH_SEARCH: begin
              if (previous_was_ff && file_byte == BYTE_SOF0) begin
                parse_phase_next = PH_SKIP1;
              end
              previous_was_ff_next = (file_byte == BYTE_FF);
            end
            PH_SKIP1, PH_SKIP2, PH_SKIP3: begin
              parse_phase_next = phase_t'(parse_phase + 3'd1);
            end
            PH_H_HI, PH_H_LO: begin
              height_shift_next = {height_shift[DIM_W-9:0], file_byte};
              parse_phase_next  = phase_t'(parse_phase + 3'd1);
            end
            PH_W_HI: begin
              width_shift_next = {width_shift[DIM_W-9:0], file_byte};
              parse_phase_next = PH_W_LO;
            end
            PH_W_LO: begin
              width_shift_next  = {width_shift[DIM_W-9:0], file_byte};
              res_valid         = 1'b1;
              res.found         = 1'b1;
              res.image_width   = {width_shift[DIM_W-9:0], file_byte};
              res.image_height  = height_shift;
              result_sent_next  = 1'b1;
            end
            default: ;
          endcase
        end
        FMT_PNG: begin
          if ((byte_position == 5'd0 && file_byte != BYTE_89) ||
              (byte_position == 5'd1 && file_byte != CHAR_P) ||
              (byte_position == 5'd2 && file_byte != CHAR_N) ||
              (byte_position == 5'd3 && file_byte != CHAR_G)) begin
            signature_ok_next = 1'b0;
          end
          if (byte_position >= 5'd16 && byte_position <= 5'd19) begin
            width_shift_next = {width_shift[DIM_W-9:0], file_byte};
          end
          if (byte_position >= 5'd20 && byte_position <= 5'd23) begin
            height_shift_next = {height_shift[DIM_W-9:0], file_byte};
          end
          if (byte_position == 5'd23 && signature_ok) begin
            res_valid        = 1'b1;
            res.found        = 1'b1;
            res.image_width  = width_shift;
            res.image_height = {height_shift[DIM_W-9:0], file_byte};
            result_sent_next = 1'b1;
          end
        end
        FMT_GIF: begin
          if ((byte_position == 5'd0 && file_byte != CHAR_G) ||
              (byte_position == 5'd1 && file_byte != CHAR_I) ||
              (byte_position == 5'd2 && file_byte != CHAR_F)) begin
            signature_ok_next = 1'b0;
          end
          if (byte_position == 5'd6) begin
            width_shift_next = {{(DIM_W-8){1'b0}}, file_byte};
          end
          if (byte_position == 5'd7) begin
            width_shift_next = width_shift | {{(DIM_W-16){1'b0}}, file_byte, 8'h00};
          end
          if (byte_position == 5'd8) begin
            height_shift_next = {{(DIM_W-8){1'b0}}, file_byte};
          end
          if (byte_position == 5'd9) begin
            height_shift_next = height_shift | {{(DIM_W-16){1'b0}}, file_byte, 8'h00};
            if (signature_ok) begin
              res_valid        = 1'b1;
              res.found        = 1'b1;
              res.image_width  = width_shift;
              res.image_height = height_shift | {{(DIM_W-16){1'b0}}, file_byte, 8'h00};
              result_sent_next = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (byte_position != POS_MAX) begin
      byte_position_next = byte_position + 5'd1;
    end

    if (last_byte) begin
      if (!result_sent_next) begin
        res_valid = 1'b1;
        res       = '0;
      end
      byte_position_next   = '0;
      parse_phase_next     = PH_SEARCH;
      previous_was_ff_next = 1'b0;
      signature_ok_next    = 1'b1;
      width_shift_next     = '0;
      height_shift_next    = '0;
      result_sent_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      parse_phase     <= PH_SEARCH;
      previous_was_ff <= 1'b0;
      signature_ok    <= 1'b1;
      width_shift     <= '0;
      height_shift    <= '0;
      result_sent     <= 1'b0;
    end else if (advance) begin
      byte_position   <= byte_position_next;
      parse_phase     <= parse_phase_next;
      previous_was_ff <= previous_was_ff_next;
      signature_ok    <= signature_ok_next;
      width_shift     <= width_shift_next;
      height_shift    <= height_shift_next;
      result_sent     <= result_sent_next;
    end
  end

  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.found) |-> (res.image_width == '0 && res.image_height == '0))
    else $error("unknown result carries nonzero dimensions");

  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.found || last_byte))
    else $error("unknown result away from the last byte");

  a_file_restart: assert property (@(posedge clk) disable iff (rst)
    (advance && last_byte) |=> (byte_position == '0 && !result_sent))
    else $error("file state not cleared after last byte");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (result_sent && !last_byte) |-> !res_valid)
    else $error("second result in one file");

endmodule

`default_nettype wire

// ===== rtl/core/ihdp_out_reg.sv =====
// Result register on the master-side stream.
`timescale 1ns / 1ps
`default_nettype none

module ihdp_out_reg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       load,
  input  wire ihdp_pkg::result_t          res,
  output logic                            free,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [ihdp_pkg::OUT_W-1:0]      m_tdata
);
  import ihdp_pkg::*;

  result_t held;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= res;
    end
  end

  // found in bit 0, width in bits 32:1, height in bits 64:33
  assign m_tdata = {{(OUT_W-1-2*DIM_W){1'b0}}, held.image_height, held.image_width,
                    held.found};

endmodule

`default_nettype wire

// ===== rtl/core/image_header_dimension_parser.sv =====
// Top level of the image header dimension parser.
//
// Usage:
//   Feed an image file one byte per item on the slave stream: s_tdata carries
//   the byte, s_tlast marks the final byte of the file. The byte after a
//   tlast starts a new file. Set the format on the cfg channel (0 jpeg,
//   1 png, 2 gif, 3 other) while the block is idle; it resets to other.
//   Each file yields exactly one item on the master stream: found = 1 with
//   width and height on the byte that completes them, or found = 0 with zero
//   dimensions on the file's last byte. Bytes after a found result are
//   dropped until the last byte.
//   Path: an accepted byte is held in the input register and parsed from
//   there; its result is loaded into the result register, which drives m_tvalid.
//   Throughput: one byte per cycle while the result register is free, set by
//   the combinational parse step between the input and result registers.
//   Stall: while a result waits on m_tready, the input register takes at most
//   one byte and holds it; s_tready stays low from then until the result is taken.
//   Reset restarts the parse state, clears both valid flags and sets the format to other.
`timescale 1ns / 1ps
`default_nettype none

module image_header_dimension_parser (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [7:0]                s_tdata,   // file_byte
  input  wire logic                      s_tlast,   // last_byte
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [ihdp_pkg::OUT_W-1:0]     m_tdata,   // found, image_width, image_height
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [1:0]                cfg_data   // image_format
);
  import ihdp_pkg::*;

  fmt_t       image_format;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_free;
  logic       advance;
  logic       res_valid;
  result_t    res;

  // Format register: always ready; the user must write it only while the block is idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_format <= FMT_OTHER;
    end else if (cfg_valid) begin
      image_format <= fmt_t'(cfg_data);
    end
  end

  // Advance the held byte whenever the result register can take its outcome
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  ihdp_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .image_format (image_format),
    .advance      (advance),
    .file_byte    (in_byte),
    .last_byte    (in_last),
    .res_valid    (res_valid),
    .res          (res)
  );

  ihdp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res_valid),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    (advance && res_valid) |=> m_tvalid)
    else $error("result lost on its way to the output register");

  a_no_advance_blocked: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !advance)
    else $error("byte consumed while result register is stalled");

  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("held byte dropped without being parsed");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of the image header dimension parser: random files, stalls, checks.
`timescale 1ns / 1ps

module tb_top;
  import ihdp_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } file_byte_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = 8'h00;   // file_byte
  logic                 s_tlast = 1'b0;    // last_byte
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;           // found, image_width, image_height
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_data = 2'd0;   // image_format

  image_header_dimension_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Free-running clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes waiting to be driven, and dimensions waiting to come out
  file_byte_t pending_bytes[$];
  result_t    expected_dims[$];
  int         queued_bytes = 0;
  int         fail_count = 0;

  // Handshakes seen at the last rising edge, read back at the falling edge
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  // Sender pacing: when set, send back to back for the whole phase
  logic tx_eager = 1'b0;

  // Shadow of the format register and of the per-file parse state
  fmt_t        fmt_reg = FMT_OTHER;
  logic [4:0]  byte_pos;
  phase_t      jpeg_phase;
  logic        saw_ff;
  logic        sig_ok;
  logic [31:0] width_acc;
  logic [31:0] height_acc;
  logic        dims_sent;

  // Return the parse state to the start of a file
  task automatic clear_file();
    byte_pos   = '0;
    jpeg_phase = PH_SEARCH;
    saw_ff     = 1'b0;
    sig_ok     = 1'b1;
    width_acc  = '0;
    height_acc = '0;
    dims_sent  = 1'b0;
  endtask

  task automatic push_dims(input logic ok, input logic [31:0] w, input logic [31:0] h);
    result_t r;
    r.found        = ok;
    r.image_width  = w;
    r.image_height = h;
    expected_dims.push_back(r);
    dims_sent = 1'b1;
  endtask

  // Advance the shadow parser by one accepted byte, queue what it yields
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [4:0] pos;
    pos = byte_pos;
    if (!dims_sent) begin
      case (fmt_reg)
        FMT_JPEG: begin
          if (jpeg_phase == PH_SEARCH) begin
            // marker may start at any offset, odd ones too
            if (saw_ff && b == BYTE_SOF0) jpeg_phase = PH_SKIP1;
            saw_ff = (b == BYTE_FF);
          end else if (jpeg_phase < PH_H_HI) begin
            jpeg_phase = phase_t'(jpeg_phase + 3'd1);
          end else begin
            if (jpeg_phase < PH_W_HI) height_acc = {height_acc[23:0], b};
            else width_acc = {width_acc[23:0], b};
            if (jpeg_phase == PH_W_LO) push_dims(1'b1, width_acc, height_acc);
            else jpeg_phase = phase_t'(jpeg_phase + 3'd1);
          end
        end
        FMT_PNG: begin
          if ((pos == 0 && b != BYTE_89) || (pos == 1 && b != CHAR_P) ||
              (pos == 2 && b != CHAR_N) || (pos == 3 && b != CHAR_G))
            sig_ok = 1'b0;
          if (pos >= 16 && pos <= 19) width_acc = {width_acc[23:0], b};
          if (pos >= 20 && pos <= 23) height_acc = {height_acc[23:0], b};
          if (pos == 23 && sig_ok) push_dims(1'b1, width_acc, height_acc);
        end
        FMT_GIF: begin
          if ((pos == 0 && b != CHAR_G) || (pos == 1 && b != CHAR_I) ||
              (pos == 2 && b != CHAR_F))
            sig_ok = 1'b0;
          if (pos == 6) width_acc = {24'd0, b};
          if (pos == 7) width_acc = width_acc | {16'd0, b, 8'd0};
          if (pos == 8) height_acc = {24'd0, b};
          if (pos == 9) height_acc = height_acc | {16'd0, b, 8'd0};
          if (pos == 9 && sig_ok) push_dims(1'b1, width_acc, height_acc);
        end
        default: ;
      endcase
    end
    if (byte_pos != POS_MAX) byte_pos = byte_pos + 5'd1;
    // last byte: report unknown if nothing came out, then start over
    if (last) begin
      if (!dims_sent) push_dims(1'b0, '0, '0);
      clear_file();
    end
  endtask

  // Sample both streams at the rising edge: check results, then predict
  always @(posedge clk) begin : watch_streams
    result_t want;
    logic        got_found;
    logic [31:0] got_w;
    logic [31:0] got_h;
    if (rst) begin
      in_taken  = 1'b0;
      out_taken = 1'b0;
      clear_file();
      expected_dims.delete();
    end else begin
      in_taken  = s_tvalid && s_tready;
      out_taken = m_tvalid && m_tready;
      if (out_taken) begin
        got_found = m_tdata[0];
        got_w     = m_tdata[32:1];
        got_h     = m_tdata[64:33];
        if (expected_dims.size() == 0) begin
          $display("%0t: unexpected result found=%0b width=%h height=%h",
                   $time, got_found, got_w, got_h);
          fail_count++;
        end else begin
          want = expected_dims.pop_front();
          if (got_found !== want.found) begin
            $display("%0t: found mismatch, expected %0b actual %0b",
                     $time, want.found, got_found);
            fail_count++;
          end
          if (got_w !== want.image_width) begin
            $display("%0t: image_width mismatch, expected %h actual %h",
                     $time, want.image_width, got_w);
            fail_count++;
          end
          if (got_h !== want.image_height) begin
            $display("%0t: image_height mismatch, expected %h actual %h",
                     $time, want.image_height, got_h);
            fail_count++;
          end
        end
      end
      if (in_taken) parse_byte(s_tdata, s_tlast);
    end
  end

  // Byte driver: hold an offered byte until taken, then idle for the drawn gap
  int send_gap = 0;
  always @(negedge clk) begin : drive_bytes
    file_byte_t nxt;
    if (!rst && !(s_tvalid && !in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        nxt = pending_bytes.pop_front();
        s_tdata  <= nxt.b;
        s_tlast  <= nxt.last;
        s_tvalid <= 1'b1;
        send_gap = tx_eager ? 0 : $urandom_range(0, 13);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: stall per result, run eager in alternate blocks of 64,
  // and twice hold off for a long stretch so the block backs up its input
  int results_seen = 0;
  int rx_stall = 0;
  int rx_hold = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) begin
        results_seen++;
        rx_stall = results_seen[6] ? 0 : $urandom_range(0, 13);
        if (results_seen == 20 || results_seen == 70) rx_hold = 400;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic last);
    file_byte_t fb;
    fb.b    = b;
    fb.last = last;
    pending_bytes.push_back(fb);
    queued_bytes++;
  endtask

  // Wait until every byte is in and every result out, then let the pipe settle
  task automatic wait_drained();
    @(posedge clk);
    while (pending_bytes.size() != 0 || s_tvalid || expected_dims.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_format(input fmt_t f);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= f;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fmt_reg = f;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_dim();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Queue one file: mostly well-formed headers with random content, the rest
  // bad signatures, truncated files and plain noise
  task automatic queue_file(input fmt_t f);
    logic [7:0] img[$];
    int   kind;
    int   keep;
    int   idx;
    fmt_t shape;
    kind  = $urandom_range(0, 9);
    shape = (f == FMT_OTHER) ? fmt_t'($urandom_range(0, 2)) : f;
    if (kind >= 8) begin
      repeat ($urandom_range(1, 40)) img.push_back(8'($urandom));
    end else begin
      case (shape)
        FMT_PNG: begin
          img.push_back(BYTE_89);
          img.push_back(CHAR_P);
          img.push_back(CHAR_N);
          img.push_back(CHAR_G);
          repeat (12) img.push_back(8'($urandom));
          repeat (8) img.push_back(pick_dim());
        end
        FMT_GIF: begin
          img.push_back(CHAR_G);
          img.push_back(CHAR_I);
          img.push_back(CHAR_F);
          repeat (3) img.push_back(8'($urandom));
          repeat (4) img.push_back(pick_dim());
        end
        default: begin
          repeat ($urandom_range(0, 6)) img.push_back(8'($urandom));
          img.push_back(BYTE_FF);
          img.push_back(BYTE_SOF0);
          repeat (3) img.push_back(8'($urandom));
          repeat (4) img.push_back(pick_dim());
        end
      endcase
      if (kind == 6) begin
        // corrupt a signature byte, or the marker byte for jpeg
        if (shape == FMT_PNG) idx = $urandom_range(0, 3);
        else if (shape == FMT_GIF) idx = $urandom_range(0, 2);
        else idx = img.size() - 8;
        img[idx] = img[idx] ^ 8'($urandom_range(1, 255));
      end else if (kind == 7) begin
        keep = $urandom_range(1, img.size() - 1);
        while (img.size() > keep) void'(img.pop_back());
      end else if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 12)) img.push_back(8'($urandom));
      end
    end
    foreach (img[i]) put_byte(img[i], i == img.size() - 1);
  endtask

  initial begin : run_files
    int   phase;
    int   phase_start;
    fmt_t f;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: other format gives unknown
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b1);
    wait_drained();

    // GIF with extreme dimensions completing on the last byte
    write_format(FMT_GIF);
    put_byte(CHAR_G, 1'b0);
    put_byte(CHAR_I, 1'b0);
    put_byte(CHAR_F, 1'b0);
    repeat (3) put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b1);
    wait_drained();

    // JPEG with the marker at an odd offset
    write_format(FMT_JPEG);
    put_byte(8'h00, 1'b0);
    put_byte(BYTE_FF, 1'b0);
    put_byte(BYTE_SOF0, 1'b0);
    put_byte(8'h11, 1'b0);
    put_byte(8'h22, 1'b0);
    put_byte(8'h33, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h12, 1'b0);
    put_byte(8'h34, 1'b1);
    wait_drained();

    // PNG with a bad signature byte, cut short
    write_format(FMT_PNG);
    put_byte(BYTE_89, 1'b0);
    put_byte(CHAR_P, 1'b0);
    put_byte(CHAR_N, 1'b0);
    put_byte(8'h00, 1'b1);
    wait_drained();

    // Random phases: visit every format first, then pick at random
    phase = 0;
    while (queued_bytes < 1800) begin
      f = (phase < 4) ? fmt_t'(phase) : fmt_t'($urandom_range(0, 3));
      write_format(f);
      tx_eager = ($urandom_range(0, 3) == 0);
      phase_start = queued_bytes;
      while (queued_bytes - phase_start < 100) queue_file(f);
      // sometimes leave a file open so the next format picks it up mid-file
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 8)) put_byte(8'($urandom), 1'b0);
      wait_drained();
      phase++;
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("image_header_dimension_parser regression: pass");
    else
      $display("image_header_dimension_parser regression: fail");
    $finish;
  end

  // Watchdog: end a hung run
  initial begin
    #5_000_000;
    $display("image_header_dimension_parser regression: fail");
    $finish;
  end

endmodule
